// ===== sv/vurp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vurp_pkg
// Shared types, codes and constants of the video unit register port.
// ----------------------------------------------------------------------------
package vurp_pkg;

  // Transaction kinds on the input tuser
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_e;

  // Register indexes
  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  // Pattern store geometry
  localparam int unsigned PAT_DEPTH = 8192;
  localparam int unsigned PAT_AW    = 13;
  localparam int unsigned PAL_DEPTH = 32;
  localparam int unsigned PAL_AW    = 5;

  // Video memory map, on the 14-bit masked address
  localparam logic [13:0] NT_BASE  = 14'h2000;
  localparam logic [13:0] PAL_BASE = 14'h3F00;

  // Tick positions
  localparam logic signed [9:0] LINE_PRERENDER = -10'sd1;
  localparam logic signed [9:0] LINE_VBLANK    = 10'sd241;
  localparam logic [8:0]        DOT_EVENT      = 9'd1;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_FILL
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic clr_step;   // write one zero of the clearing pass
    logic accept;     // input transaction taken this cycle
    logic finish_rd;  // pattern read data is back, complete the item
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_valid;  // output register holds a result
    logic clr_last;   // clearing pass at its last entry
    logic needs_wait; // presented item is a data read from the pattern store
  } dp_status_t;

  // Palette mirroring: entries 0x10/0x14/0x18/0x1C fold onto 0x00/0x04/0x08/0x0C
  function automatic logic [PAL_AW-1:0] pal_slot(input logic [13:0] addr);
    logic [PAL_AW-1:0] p;
    p = addr[PAL_AW-1:0];
    if (p[1:0] == 2'b00) begin
      p[4] = 1'b0;
    end
    return p;
  endfunction

endpackage

// ===== sv/video_unit_register_port.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_unit_register_port
// Picture-unit register port: vblank timing ticks and register transactions
// to control, status, video address and video memory.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload
//  s_axis    in   tuser: kind; tdata: reg_index, write_data, scanline, dot
//  m_axis    out  tdata: read_data, nmi_request (one result per item)
//
//  Rate: one item per clock while m_axis takes results; a data-port read
//  hitting the pattern store holds the input for the registered RAM read.
//  Reset: after rst_ni rises, a clearing pass zeroes the 8192-entry pattern
//  RAM, one entry per cycle, with s_axis_tready_o low until it is done.
//  Stalls: the result sits in an output register; a new transaction is taken
//  while it drains; it stalls if m_axis is held off or in the clear/fill states.
//
module video_unit_register_port (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [2:0] reg_index, [10:3] write_data,
                                       // [20:11] scanline (signed), [29:21] dot
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] kind
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // [7:0] read_data, [8] nmi_request
);

  vurp_pkg::ctrl_cmd_t  cmd;
  vurp_pkg::dp_status_t status;
  logic [7:0]           read_data;
  logic                 nmi_request;

  // sequencing: clearing pass, handshake, pattern read wait
  vurp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .in_ready_o  (s_axis_tready_o),
    .cmd_o       (cmd)
  );

  // registers, memories and the output register
  vurp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .kind_i        (s_axis_tuser_i),
    .reg_index_i   (s_axis_tdata_i[2:0]),
    .write_data_i  (s_axis_tdata_i[10:3]),
    .scanline_i    (s_axis_tdata_i[20:11]),
    .dot_i         (s_axis_tdata_i[29:21]),
    .out_ready_i   (m_axis_tready_i),
    .read_data_o   (read_data),
    .nmi_request_o (nmi_request)
  );

  assign m_axis_tvalid_o = status.out_valid;
  assign m_axis_tdata_o  = {7'b0, nmi_request, read_data};

endmodule

// ===== sv/vurp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vurp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vurp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/vurp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vurp_ctrl
// Controller: clearing pass after reset, input handshake, pattern read wait.
// ----------------------------------------------------------------------------
module vurp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_ready_i,
  input  vurp_pkg::dp_status_t status_i,
  output logic                in_ready_o,
  output vurp_pkg::ctrl_cmd_t  cmd_o
);

  vurp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vurp_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    unique case (state_q)
      vurp_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = vurp_pkg::ST_RUN;
        end
      end
      vurp_pkg::ST_RUN: begin
        // output slot free, or draining this cycle
        in_ready_o   = !status_i.out_valid || out_ready_i;
        cmd_o.accept = in_ready_o && in_valid_i;
        if (cmd_o.accept && status_i.needs_wait) begin
          state_d = vurp_pkg::ST_FILL;
        end
      end
      vurp_pkg::ST_FILL: begin
        cmd_o.finish_rd = 1'b1;
        state_d         = vurp_pkg::ST_RUN;
      end
      default: begin
        state_d = vurp_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== sv/vurp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vurp_dp
// Datapath: register file, palette, pattern RAM, clear counter, output stage.
// ----------------------------------------------------------------------------
module vurp_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vurp_pkg::ctrl_cmd_t   cmd_i,
  output vurp_pkg::dp_status_t  status_o,
  input  logic [1:0]           kind_i,
  input  logic [2:0]           reg_index_i,
  input  logic [7:0]           write_data_i,
  input  logic signed [9:0]    scanline_i,
  input  logic [8:0]           dot_i,
  input  logic                 out_ready_i,
  output logic [7:0]           read_data_o,
  output logic                 nmi_request_o
);

  // architectural state
  logic        vblank_q, vblank_d;
  logic [7:0]  control_q, control_d;
  logic        phase_q, phase_d;
  logic [15:0] vaddr_q, vaddr_d;
  logic [7:0]  rbuf_q, rbuf_d;
  logic [7:0]  palette_q [vurp_pkg::PAL_DEPTH];

  // clearing pass
  logic [vurp_pkg::PAT_AW-1:0] clr_cnt_q;

  // output stage
  logic       out_valid_q, out_valid_d;
  logic [7:0] rd_q, rd_d;
  logic       nmi_q, nmi_d;

  // memory path
  logic [13:0]                 maddr;
  logic                        is_pat, is_pal;
  logic [vurp_pkg::PAL_AW-1:0] slot;
  logic                        pal_we;
  logic                        ram_we, ram_re;
  logic [vurp_pkg::PAT_AW-1:0] ram_waddr;
  logic [7:0]                  ram_wdata, ram_rdata;
  logic                        is_rd_data, is_wr_data;
  vurp_pkg::kind_e             kind;

  assign kind   = vurp_pkg::kind_e'(kind_i);
  assign maddr  = vaddr_q[13:0];
  assign is_pat = maddr < vurp_pkg::NT_BASE;
  assign is_pal = maddr >= vurp_pkg::PAL_BASE;
  assign slot   = vurp_pkg::pal_slot(maddr);

  assign is_rd_data = (kind == vurp_pkg::KIND_READ) && (reg_index_i == vurp_pkg::REG_DATA);
  assign is_wr_data = (kind == vurp_pkg::KIND_WRITE) && (reg_index_i == vurp_pkg::REG_DATA);

  assign status_o.out_valid  = out_valid_q;
  assign status_o.clr_last   = clr_cnt_q == vurp_pkg::PAT_AW'(vurp_pkg::PAT_DEPTH - 1);
  assign status_o.needs_wait = is_rd_data && is_pat;

  // RAM ports: clearing pass owns the write port until done
  assign ram_we    = cmd_i.clr_step || (cmd_i.accept && is_wr_data && is_pat);
  assign ram_waddr = cmd_i.clr_step ? clr_cnt_q : maddr[vurp_pkg::PAT_AW-1:0];
  assign ram_wdata = cmd_i.clr_step ? 8'h00 : write_data_i;
  assign ram_re    = cmd_i.accept && is_rd_data && is_pat;
  assign pal_we    = cmd_i.accept && is_wr_data && is_pal;

  vurp_ram #(
    .Width (8),
    .Depth (vurp_pkg::PAT_DEPTH)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (maddr[vurp_pkg::PAT_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    vblank_d    = vblank_q;
    control_d   = control_q;
    phase_d     = phase_q;
    vaddr_d     = vaddr_q;
    rbuf_d      = rbuf_q;
    rd_d        = rd_q;
    nmi_d       = nmi_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cmd_i.finish_rd) begin
      // buffered read: old buffer goes out, RAM byte refills it
      rbuf_d      = ram_rdata;
      rd_d        = rbuf_q;
      nmi_d       = 1'b0;
      out_valid_d = 1'b1;
    end else if (cmd_i.accept) begin
      rd_d        = 8'h00;
      nmi_d       = 1'b0;
      out_valid_d = !status_o.needs_wait;
      unique case (kind)
        vurp_pkg::KIND_TICK: begin
          if (dot_i == vurp_pkg::DOT_EVENT) begin
            if (scanline_i == vurp_pkg::LINE_PRERENDER) begin
              vblank_d = 1'b0;
            end
            if (scanline_i == vurp_pkg::LINE_VBLANK) begin
              vblank_d = 1'b1;
              nmi_d    = control_q[7];
            end
          end
        end
        vurp_pkg::KIND_READ: begin
          if (reg_index_i == vurp_pkg::REG_STATUS) begin
            rd_d     = {vblank_q, 7'b0};
            vblank_d = 1'b0;
            phase_d  = 1'b0;
          end else if (reg_index_i == vurp_pkg::REG_DATA) begin
            vaddr_d = vaddr_q + 16'd1;
            if (is_pal) begin
              rbuf_d = palette_q[slot];
              rd_d   = palette_q[slot];
            end else if (!is_pat) begin
              // nametable range: old buffer goes out, buffer refills with zero
              rbuf_d = 8'h00;
              rd_d   = rbuf_q;
            end
          end
        end
        vurp_pkg::KIND_WRITE: begin
          if (reg_index_i == vurp_pkg::REG_CTRL) begin
            control_d = write_data_i;
          end else if (reg_index_i == vurp_pkg::REG_ADDR) begin
            if (!phase_q) begin
              vaddr_d = {write_data_i, vaddr_q[7:0]};
            end else begin
              vaddr_d = {vaddr_q[15:8], write_data_i};
            end
            phase_d = !phase_q;
          end else if (reg_index_i == vurp_pkg::REG_DATA) begin
            vaddr_d = vaddr_q + 16'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vblank_q    <= 1'b0;
      control_q   <= 8'h00;
      phase_q     <= 1'b0;
      vaddr_q     <= 16'h0000;
      rbuf_q      <= 8'h00;
      out_valid_q <= 1'b0;
      clr_cnt_q   <= '0;
    end else begin
      vblank_q    <= vblank_d;
      control_q   <= control_d;
      phase_q     <= phase_d;
      vaddr_q     <= vaddr_d;
      rbuf_q      <= rbuf_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(vurp_pkg::PAL_DEPTH); i++) begin
        palette_q[i] <= 8'h00;
      end
    end else if (pal_we) begin
      palette_q[slot] <= write_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q  <= rd_d;
    nmi_q <= nmi_d;
  end

  assign read_data_o   = rd_q;
  assign nmi_request_o = nmi_q;

endmodule
